### rtl/dks_pkg.sv
// Shared constants, tables, types and bit-selection functions of the DES key schedule.
package dks_pkg;

    localparam int KeyBits  = 64;
    localparam int Half     = 28;
    localparam int CdBits   = 56;
    localparam int RkBits   = 48;
    localparam int SlotBits = 4;

    localparam logic [SlotBits-1:0] LastSlot = 4'd15;

    // Rounds with a single-bit rotation: 1, 2, 9 and 16 (indices 0, 1, 8, 15).
    localparam logic [15:0] SingleShift = 16'h8103;

    typedef logic [Half-1:0] half_t;

    typedef struct packed {
        logic load;
        logic step;
        logic left;
        logic two;
    } dks_ctl_t;

    localparam logic [6:0] PC1_TAB [CdBits] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
        7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
        7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
        7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
        7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
        7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
        7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
    };

    localparam logic [6:0] PC2_TAB [RkBits] = '{
        7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,
        7'd3,  7'd28, 7'd15, 7'd6,  7'd21, 7'd10,
        7'd23, 7'd19, 7'd12, 7'd4,  7'd26, 7'd8,
        7'd16, 7'd7,  7'd27, 7'd20, 7'd13, 7'd2,
        7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55,
        7'd30, 7'd40, 7'd51, 7'd45, 7'd33, 7'd48,
        7'd44, 7'd49, 7'd39, 7'd56, 7'd34, 7'd53,
        7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32
    };

    function automatic logic [CdBits-1:0] pc1(input logic [KeyBits-1:0] k);
        logic [CdBits-1:0] r;
        r = '0;
        for (int i = 0; i < CdBits; i++) begin
            r[CdBits-1-i] = k[6'(7'd64 - PC1_TAB[i])];
        end
        return r;
    endfunction

    function automatic logic [RkBits-1:0] pc2(input logic [CdBits-1:0] cd);
        logic [RkBits-1:0] r;
        r = '0;
        for (int i = 0; i < RkBits; i++) begin
            r[RkBits-1-i] = cd[6'(7'd56 - PC2_TAB[i])];
        end
        return r;
    endfunction

endpackage

### rtl/dks_cell.sv
// One bit position of the C and D rotation ring.
module dks_cell
    import dks_pkg::*;
(
    input  logic     clk,
    input  dks_ctl_t ctl,
    input  logic     load_c,
    input  logic     load_d,
    input  logic [3:0] c_nbr,
    input  logic [3:0] d_nbr,
    output logic     c,
    output logic     d
);

    logic c_reg;
    logic d_reg;
    logic c_next;
    logic d_next;

    // nbr order: {i+2, i+1, i-1, i-2}
    always_comb
    begin
        c_next = c_reg;
        d_next = d_reg;
        priority if (ctl.load)
        begin
            c_next = load_c;
            d_next = load_d;
        end
        else if (ctl.step)
        begin
            if (ctl.left)
            begin
                c_next = ctl.two ? c_nbr[0] : c_nbr[1];
                d_next = ctl.two ? d_nbr[0] : d_nbr[1];
            end
            else
            begin
                c_next = ctl.two ? c_nbr[3] : c_nbr[2];
                d_next = ctl.two ? d_nbr[3] : d_nbr[2];
            end
        end
        else
        begin
            c_next = c_reg;
            d_next = d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
        d_reg <= d_next;
    end

    assign c = c_reg;
    assign d = d_reg;

endmodule

### rtl/dks_out_stage.sv
// Output register holding one round-key request until it is taken.
module dks_out_stage
    import dks_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic [RkBits-1:0]   load_subkey,
    input  logic [SlotBits-1:0] load_slot,
    input  logic                load_last,
    input  logic                out_ready,
    output logic                free,
    output logic                out_valid,
    output logic [RkBits-1:0]   subkey,
    output logic [SlotBits-1:0] slot,
    output logic                last
);

    logic                valid_reg;
    logic                valid_next;
    logic [RkBits-1:0]   subkey_reg;
    logic [SlotBits-1:0] slot_reg;
    logic                last_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        priority if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            subkey_reg <= load_subkey;
            slot_reg   <= load_slot;
            last_reg   <= load_last;
        end
    end

    assign out_valid = valid_reg;
    assign subkey    = subkey_reg;
    assign slot      = slot_reg;
    assign last      = last_reg;

endmodule

### rtl/des_key_schedule_unit.sv
// DES key schedule: rotation ring of bit cells, slot sequencer and output register.
// The edge that accepts a key request loads the ring; each step emits a round key.
// Throughput: one round key per cycle unless the output stalls; the next key is taken
// in the cycle its predecessor's last round key enters the output register.
// The ring steps once per delivered round key; a stalled output stalls the ring.
// Reset (rst_n low, asynchronous) clears busy and output valid; ring data is not reset.
module des_key_schedule_unit
    import dks_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [KeyBits-1:0]  key,
    input  logic                decrypt,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [RkBits-1:0]   subkey,
    output logic [SlotBits-1:0] slot,
    output logic                last
);

    logic                busy_reg;
    logic                busy_next;
    logic                dec_reg;
    logic                dec_next;
    logic [SlotBits-1:0] count_reg;
    logic [SlotBits-1:0] count_next;

    logic                free;
    logic                step;
    logic                accept;
    logic                at_last;
    logic [SlotBits-1:0] shift_idx;
    logic [CdBits-1:0]   cd_init;
    half_t               c_init;
    half_t               d_init;
    half_t               c_load;
    half_t               d_load;
    half_t               c_vec;
    half_t               d_vec;
    dks_ctl_t            ctl;

    assign at_last  = (count_reg == LastSlot);
    assign step     = busy_reg && free;
    assign in_ready = !busy_reg || (step && at_last);
    assign accept   = in_valid && in_ready;

    assign cd_init = pc1(key);
    assign c_init  = cd_init[CdBits-1:Half];
    assign d_init  = cd_init[Half-1:0];
    assign c_load  = decrypt ? c_init : {c_init[Half-2:0], c_init[Half-1]};
    assign d_load  = decrypt ? d_init : {d_init[Half-2:0], d_init[Half-1]};

    assign shift_idx = dec_reg ? ~count_reg : SlotBits'(count_reg + 1'b1);

    always_comb
    begin
        ctl.load = accept;
        ctl.step = step;
        ctl.left = !dec_reg;
        ctl.two  = !SingleShift[shift_idx];
    end

    always_comb
    begin
        busy_next  = busy_reg;
        dec_next   = dec_reg;
        count_next = count_reg;
        priority if (accept)
        begin
            busy_next  = 1'b1;
            dec_next   = decrypt;
            count_next = '0;
        end
        else if (step)
        begin
            busy_next  = !at_last;
            count_next = SlotBits'(count_reg + 1'b1);
        end
        else
        begin
            busy_next  = busy_reg;
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            dec_reg   <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            dec_reg   <= dec_next;
            count_reg <= count_next;
        end
    end

    for (genvar i = 0; i < Half; i++)
    begin : g_ring
        localparam int IP1 = (i + 1) % Half;
        localparam int IP2 = (i + 2) % Half;
        localparam int IM1 = (i + Half - 1) % Half;
        localparam int IM2 = (i + Half - 2) % Half;

        dks_cell u_cell (
            .clk    (clk),
            .ctl    (ctl),
            .load_c (c_load[i]),
            .load_d (d_load[i]),
            .c_nbr  ({c_vec[IP2], c_vec[IP1], c_vec[IM1], c_vec[IM2]}),
            .d_nbr  ({d_vec[IP2], d_vec[IP1], d_vec[IM1], d_vec[IM2]}),
            .c      (c_vec[i]),
            .d      (d_vec[i])
        );
    end

    dks_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (step),
        .load_subkey (pc2({c_vec, d_vec})),
        .load_slot   (count_reg),
        .load_last   (at_last),
        .out_ready   (out_ready),
        .free        (free),
        .out_valid   (out_valid),
        .subkey      (subkey),
        .slot        (slot),
        .last        (last)
    );

endmodule

### rtl/dks_checker.sv
// Port-level checker for the DES key schedule unit, with its bind statement.
module dks_checker
    import dks_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic [KeyBits-1:0]  key,
    input logic                decrypt,
    input logic                out_valid,
    input logic                out_ready,
    input logic [RkBits-1:0]   subkey,
    input logic [SlotBits-1:0] slot,
    input logic                last
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_ready) |=> (in_valid && $stable(key) && $stable(decrypt)))
        else $error("key request dropped or changed while waiting");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(subkey) && $stable(slot) && $stable(last)))
        else $error("output request dropped or changed while stalled");

    a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (slot == LastSlot)))
        else $error("last flag does not match final slot");

    a_slot_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=>
            (out_valid && (slot == SlotBits'($past(slot) + 1'b1))))
        else $error("round keys not delivered in consecutive slots");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken again right after a key request");

endmodule

bind des_key_schedule_unit dks_checker u_dks_checker (.*);
